FILE: src/sprite_row_pixel_fetch_unit_macros.svh
// assertion macros for the sprite row pixel fetch unit
// expects clk and rst in the scope where a macro is used
`ifndef SPRITE_ROW_PIXEL_FETCH_UNIT_MACROS_SVH
`define SPRITE_ROW_PIXEL_FETCH_UNIT_MACROS_SVH

// same-cycle implication
`define SRPF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sprite row fetch check failed");

// next-cycle implication
`define SRPF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sprite row fetch check failed");

`endif

FILE: src/srpf_pkg.sv
// shared types and constants for the sprite row pixel fetch unit
// no dependencies
`default_nettype none

package srpf_pkg;

  localparam int SCREEN_WIDTH    = 160;
  localparam int SCREEN_HEIGHT   = 144;
  localparam int PIXELS_PER_ROW  = 8;
  localparam int SPRITE_Y_OFFSET = 16;
  localparam int SPRITE_X_OFFSET = 8;

  localparam int TILE_MEM_DEPTH  = 4096;
  localparam int BANK_DEPTH      = TILE_MEM_DEPTH / 2;
  localparam int BANK_AW         = $clog2(BANK_DEPTH);

  localparam logic [8:0] Y_LIMIT = 9'(SCREEN_HEIGHT + SPRITE_Y_OFFSET);
  localparam logic [8:0] X_LIMIT = 9'(SCREEN_WIDTH + SPRITE_X_OFFSET);

  localparam logic [1:0] REG_TALL_SPRITES    = 2'd0;
  localparam logic [1:0] REG_SPRITES_ENABLED = 2'd1;
  localparam logic [1:0] REG_PALETTE_ZERO    = 2'd2;
  localparam logic [1:0] REG_PALETTE_ONE     = 2'd3;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_RENDER = 1'b1;

  localparam int FLAG_BEHIND  = 7;
  localparam int FLAG_Y_FLIP  = 6;
  localparam int FLAG_X_FLIP  = 5;
  localparam int FLAG_PALETTE = 4;

  typedef struct packed {
    logic        mode;
    logic [11:0] tile_address;
    logic [7:0]  tile_data;
    logic [7:0]  sprite_y;
    logic [7:0]  sprite_x;
    logic [7:0]  tile_number;
    logic [7:0]  sprite_flags;
    logic [7:0]  current_line;
  } srpf_req_t;

  typedef struct packed {
    logic        covers_line;
    logic [15:0] pixel_shades;
    logic [7:0]  opaque_mask;
    logic        behind_background;
  } srpf_res_t;

  typedef struct packed {
    logic       hit;
    logic       x_flip;
    logic       behind;
    logic [7:0] palette;
  } srpf_ctrl_t;

endpackage

`default_nettype wire

FILE: src/sprite_row_pixel_fetch_unit.sv
// sprite row pixel fetch unit: tile pattern memory and sprite row render
// depends on srpf_pkg, srpf_shader and sprite_row_pixel_fetch_unit_macros.svh
// one request per cycle while busy is low; a render request gives its result on done
// through the tile memory read register, then the shading register; a write gives none
// reset clears config registers and the pipeline, not tile memory; busy is a register
// that is set during reset and cleared once reset is released
`default_nettype none
`include "sprite_row_pixel_fetch_unit_macros.svh"

module sprite_row_pixel_fetch_unit (
  input  var logic                clk,
  input  var logic                rst,
  input  var logic                start,
  output logic                    busy,
  input  var srpf_pkg::srpf_req_t request,
  output logic                    done,
  output srpf_pkg::srpf_res_t     result,
  input  var logic                cfg_we,
  input  var logic [1:0]          cfg_index,
  input  var logic [7:0]          cfg_data
);
  import srpf_pkg::*;

  logic       tall_sprites;
  logic       sprites_enabled;
  logic [7:0] palette_zero;
  logic [7:0] palette_one;

  // even and odd bytes in separate banks so both planes read together
  logic [7:0] even_bank [BANK_DEPTH];
  logic [7:0] odd_bank  [BANK_DEPTH];

  logic               accept;
  logic               hidden;
  logic               covered;
  logic [9:0]         row_diff;
  logic [4:0]         height;
  logic [3:0]         row;
  logic [3:0]         row_sel;
  logic [7:0]         tile_eff;
  logic [BANK_AW-1:0] read_index;
  logic [BANK_AW-1:0] write_index;
  srpf_ctrl_t         ctrl_next;

  logic       s1_valid;
  srpf_ctrl_t s1_ctrl;
  logic [7:0] plane_lo;
  logic [7:0] plane_hi;
  srpf_res_t  result_next;

  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tall_sprites    <= 1'b0;
      sprites_enabled <= 1'b0;
      palette_zero    <= '0;
      palette_one     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TALL_SPRITES:    tall_sprites    <= cfg_data[0];
        REG_SPRITES_ENABLED: sprites_enabled <= cfg_data[0];
        REG_PALETTE_ZERO:    palette_zero    <= cfg_data;
        REG_PALETTE_ONE:     palette_one     <= cfg_data;
        default: ;
      endcase
    end
  end

  // row selection and bank address
  always_comb begin
    hidden = ~sprites_enabled
           || request.sprite_y == 8'd0 || {1'b0, request.sprite_y} >= Y_LIMIT
           || request.sprite_x == 8'd0 || {1'b0, request.sprite_x} >= X_LIMIT;
    height   = tall_sprites ? 5'd16 : 5'd8;
    row_diff = {2'b00, request.current_line} + 10'(SPRITE_Y_OFFSET)
             - {2'b00, request.sprite_y};
    covered  = ~row_diff[9] && (row_diff < {5'b00000, height});
    row      = row_diff[3:0];
    if (request.sprite_flags[FLAG_Y_FLIP]) begin
      row_sel = tall_sprites ? ~row : {1'b0, ~row[2:0]};
    end else begin
      row_sel = row;
    end
    tile_eff   = tall_sprites ? {request.tile_number[7:1], 1'b0} : request.tile_number;
    read_index = {tile_eff, 3'b000} + {7'b0000000, row_sel};
    write_index = request.tile_address[11:1];

    ctrl_next.hit     = ~hidden & covered;
    ctrl_next.x_flip  = request.sprite_flags[FLAG_X_FLIP];
    ctrl_next.behind  = request.sprite_flags[FLAG_BEHIND];
    ctrl_next.palette = request.sprite_flags[FLAG_PALETTE] ? palette_one : palette_zero;
  end

  always_ff @(posedge clk) begin
    if (accept && request.mode == MODE_WRITE && !request.tile_address[0]) begin
      even_bank[write_index] <= request.tile_data;
    end
    if (accept && request.mode == MODE_RENDER) begin
      plane_lo <= even_bank[read_index];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && request.mode == MODE_WRITE && request.tile_address[0]) begin
      odd_bank[write_index] <= request.tile_data;
    end
    if (accept && request.mode == MODE_RENDER) begin
      plane_hi <= odd_bank[read_index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= accept && request.mode == MODE_RENDER;
      done     <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && request.mode == MODE_RENDER) begin
      s1_ctrl <= ctrl_next;
    end
    if (s1_valid) begin
      result <= result_next;
    end
  end

  srpf_shader u_shader (
    .plane_lo (plane_lo),
    .plane_hi (plane_hi),
    .ctrl     (s1_ctrl),
    .res      (result_next)
  );

  `SRPF_ASSERT_NEXT(a_render_reaches_done, s1_valid, done)
  `SRPF_ASSERT_NEXT(a_write_no_result, accept && request.mode == MODE_WRITE, !s1_valid)
  `SRPF_ASSERT_NOW(a_miss_is_blank, done && !result.covers_line, result == '0)

endmodule

`default_nettype wire

FILE: src/srpf_shader.sv
// maps one fetched tile row (two bit planes) to eight palette shades
// depends on srpf_pkg
`default_nettype none

module srpf_shader (
  input  var logic [7:0]          plane_lo,
  input  var logic [7:0]          plane_hi,
  input  var srpf_pkg::srpf_ctrl_t ctrl,
  output srpf_pkg::srpf_res_t     res
);
  import srpf_pkg::*;

  always_comb begin
    logic [1:0] colour;
    logic [2:0] sel;
    res = '0;
    for (int i = 0; i < PIXELS_PER_ROW; i++) begin
      sel    = ctrl.x_flip ? 3'(i) : 3'(PIXELS_PER_ROW - 1 - i);
      colour = {plane_hi[sel], plane_lo[sel]};
      if (ctrl.hit && colour != 2'd0) begin
        res.pixel_shades[2*i +: 2] = ctrl.palette[2*colour +: 2];
        res.opaque_mask[i]         = 1'b1;
      end
    end
    res.covers_line       = ctrl.hit;
    res.behind_background = ctrl.hit & ctrl.behind;
  end

endmodule

`default_nettype wire
